FILE: rtl/core/pcbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types, constants and the control store of the prefix code packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_IN_W = 6;
    localparam int ACC_W   = SYM_W + CODE_W;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_ENCODE = 1'b1;

    // sequencer steps
    localparam int STEP_W = 2;
    localparam logic [STEP_W-1:0] ST_IDLE   = 2'd0;
    localparam logic [STEP_W-1:0] ST_LOAD   = 2'd1;
    localparam logic [STEP_W-1:0] ST_EMIT   = 2'd2;
    localparam logic [STEP_W-1:0] ST_FINISH = 2'd3;

    // datapath operations
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_EMIT   = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // jump conditions
    localparam logic [1:0] COND_ALWAYS  = 2'd0;
    localparam logic [1:0] COND_NO_ENC  = 2'd1;
    localparam logic [1:0] COND_FULL    = 2'd2;
    localparam logic [1:0] COND_NEVER   = 2'd3;

    typedef struct packed {
        logic              accept;
        logic [1:0]        op;
        logic [1:0]        cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic       take;
        logic [1:0] op;
    } ctrl_t;

    typedef struct packed {
        logic full;
        logic stall;
    } status_t;

    // control store: jump to target when the condition holds, else fall through
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        unique case (step)
            ST_IDLE:   w = '{accept: 1'b1, op: OP_NONE,   cond: COND_NO_ENC, target: ST_IDLE};
            ST_LOAD:   w = '{accept: 1'b0, op: OP_LOAD,   cond: COND_NEVER,  target: ST_IDLE};
            ST_EMIT:   w = '{accept: 1'b0, op: OP_EMIT,   cond: COND_FULL,   target: ST_EMIT};
            ST_FINISH: w = '{accept: 1'b0, op: OP_FINISH, cond: COND_ALWAYS, target: ST_IDLE};
            default:   w = '{accept: 1'b0, op: OP_NONE,   cond: COND_ALWAYS, target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pcbp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcbp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/core/pcbp_code_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_code_table
// Code table: per-symbol valid flags in flops, code and length in a RAM.
// ----------------------------------------------------------------------------
module pcbp_code_table #(
    parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT_DEF,
    parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [pcbp_pkg::SYM_W-1:0]    symbol,
    input  wire logic [pcbp_pkg::CODE_W-1:0]   code_word,
    input  wire logic [pcbp_pkg::LEN_IN_W-1:0] code_length,
    output logic                               hit,
    output logic      [pcbp_pkg::CODE_W-1:0]   rd_code,
    output logic      [LEN_W-1:0]              rd_len
);

    localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ENT_W = pcbp_pkg::CODE_W + LEN_W;

    logic [SYMBOL_COUNT-1:0]         valid_reg;
    logic [SYMBOL_COUNT-1:0]         valid_next;
    logic                            in_range;
    logic [IDX_W-1:0]                idx;
    logic [pcbp_pkg::LEN_IN_W-1:0]   len_sat;
    logic [63:0]                     len_mask;
    logic [pcbp_pkg::CODE_W-1:0]     code_masked;
    logic [ENT_W-1:0]                wdata;
    logic [ENT_W-1:0]                rdata;

    assign in_range = ({1'b0, symbol} < (pcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT));
    assign idx      = symbol[IDX_W-1:0];
    assign hit      = in_range && valid_reg[idx];

    assign len_sat = (code_length > pcbp_pkg::LEN_IN_W'(MAX_CODE_LEN))
                   ? pcbp_pkg::LEN_IN_W'(MAX_CODE_LEN) : code_length;
    // keep only the bits that will be sent
    assign len_mask    = (64'd1 << len_sat) - 64'd1;
    assign code_masked = code_word & len_mask[pcbp_pkg::CODE_W-1:0];
    assign wdata       = {code_masked, len_sat[LEN_W-1:0]};

    always_comb begin
        valid_next = valid_reg;
        if (wr_en && in_range) begin
            valid_next[idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    pcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SYMBOL_COUNT),
        .ADDR_W(IDX_W)
    ) u_ram (
        .aclk (aclk),
        .we   (wr_en && in_range),
        .waddr(idx),
        .wdata(wdata),
        .raddr(idx),
        .rdata(rdata)
    );

    assign rd_code = rdata[ENT_W-1:LEN_W];
    assign rd_len  = rdata[LEN_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/pcbp_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_sequencer
// Step counter over the control store, with conditional jumps.
// ----------------------------------------------------------------------------
module pcbp_sequencer (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire logic             in_encode,
    input  wire pcbp_pkg::status_t status,
    output logic                  in_ready,
    output pcbp_pkg::ctrl_t       ctrl
);

    logic [pcbp_pkg::STEP_W-1:0] step_reg;
    logic [pcbp_pkg::STEP_W-1:0] step_next;
    pcbp_pkg::uword_t            uw;
    logic                        jump;

    assign uw       = pcbp_pkg::ucode(step_reg);
    assign in_ready = uw.accept;
    assign ctrl     = '{take: uw.accept && in_valid, op: uw.op};

    always_comb begin
        unique case (uw.cond)
            pcbp_pkg::COND_ALWAYS: jump = 1'b1;
            pcbp_pkg::COND_NO_ENC: jump = !(in_valid && in_encode);
            pcbp_pkg::COND_FULL:   jump = status.full;
            pcbp_pkg::COND_NEVER:  jump = 1'b0;
            default:               jump = 1'b0;
        endcase
    end

    always_comb begin
        priority if (status.stall) begin
            step_next = step_reg;
        end else if (jump) begin
            step_next = uw.target;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= pcbp_pkg::ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/pcbp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_datapath
// Bit accumulator, token state and the output register.
// ----------------------------------------------------------------------------
module pcbp_datapath #(
    parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire pcbp_pkg::ctrl_t             ctrl,
    input  wire logic                        in_encode,
    input  wire logic                        in_last,
    input  wire logic                        hit,
    input  wire logic [pcbp_pkg::CODE_W-1:0] rd_code,
    input  wire logic [LEN_W-1:0]            rd_len,
    output pcbp_pkg::status_t                status,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [7:0]                  out_byte,
    output logic                             out_has,
    output logic                             out_done,
    output logic                             out_miss
);

    localparam int CNT_W = $clog2(MAX_CODE_LEN + 8);
    localparam int ACC_W = pcbp_pkg::ACC_W;

    logic             last_reg,     last_next;
    logic             miss_reg,     miss_next;
    logic             dropping_reg, dropping_next;
    logic [7:0]       pend_reg,     pend_next;
    logic [2:0]       pcnt_reg,     pcnt_next;
    logic [ACC_W-1:0] bits_reg,     bits_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic             emitted_reg,  emitted_next;
    logic             ovalid_reg,   ovalid_next;
    logic [7:0]       obyte_reg,    obyte_next;
    logic             ohas_reg,     ohas_next;
    logic             odone_reg,    odone_next;
    logic             omiss_reg,    omiss_next;

    logic out_free;
    logic full;
    logic want_final;
    logic push;

    assign out_free   = !ovalid_reg || out_ready;
    assign full       = (count_reg >= CNT_W'(8));
    assign want_final = last_reg && (dropping_reg || (count_reg != '0) || !emitted_reg);

    always_comb begin
        unique case (ctrl.op)
            pcbp_pkg::OP_EMIT:   push = full;
            pcbp_pkg::OP_FINISH: push = want_final;
            default:             push = 1'b0;
        endcase
    end

    assign status = '{full: full, stall: push && !out_free};

    always_comb begin
        last_next     = last_reg;
        miss_next     = miss_reg;
        dropping_next = dropping_reg;
        pend_next     = pend_reg;
        pcnt_next     = pcnt_reg;
        bits_next     = bits_reg;
        count_next    = count_reg;
        emitted_next  = emitted_reg;
        ovalid_next   = ovalid_reg && !out_ready;
        obyte_next    = obyte_reg;
        ohas_next     = ohas_reg;
        odone_next    = odone_reg;
        omiss_next    = omiss_reg;

        if (ctrl.take && in_encode) begin
            last_next = in_last;
            miss_next = !hit;
        end

        unique case (ctrl.op)
            pcbp_pkg::OP_LOAD: begin
                emitted_next = 1'b0;
                if (dropping_reg || miss_reg) begin
                    dropping_next = 1'b1;
                    pend_next     = '0;
                    pcnt_next     = '0;
                    bits_next     = '0;
                    count_next    = '0;
                end else begin
                    bits_next  = (ACC_W'(rd_code) << pcnt_reg) | ACC_W'(pend_reg);
                    count_next = CNT_W'(pcnt_reg) + CNT_W'(rd_len);
                end
            end
            pcbp_pkg::OP_EMIT: begin
                if (full && out_free) begin
                    ovalid_next  = 1'b1;
                    obyte_next   = bits_reg[7:0];
                    ohas_next    = 1'b1;
                    // last byte of the token when nothing is left over
                    odone_next   = last_reg && (count_reg == CNT_W'(8));
                    omiss_next   = 1'b0;
                    bits_next    = bits_reg >> 8;
                    count_next   = count_reg - CNT_W'(8);
                    emitted_next = 1'b1;
                end
            end
            pcbp_pkg::OP_FINISH: begin
                if (!last_reg) begin
                    pend_next = bits_reg[7:0];
                    pcnt_next = count_reg[2:0];
                end else if (!want_final || out_free) begin
                    if (want_final) begin
                        ovalid_next = 1'b1;
                        odone_next  = 1'b1;
                        priority if (dropping_reg) begin
                            obyte_next = '0;
                            ohas_next  = 1'b0;
                            omiss_next = 1'b1;
                        end else if (count_reg != '0) begin
                            obyte_next = bits_reg[7:0];
                            ohas_next  = 1'b1;
                            omiss_next = 1'b0;
                        end else begin
                            // empty token marker
                            obyte_next = '0;
                            ohas_next  = 1'b0;
                            omiss_next = 1'b0;
                        end
                    end
                    dropping_next = 1'b0;
                    pend_next     = '0;
                    pcnt_next     = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dropping_reg <= 1'b0;
            pend_reg     <= '0;
            pcnt_reg     <= '0;
            ovalid_reg   <= 1'b0;
        end else begin
            dropping_reg <= dropping_next;
            pend_reg     <= pend_next;
            pcnt_reg     <= pcnt_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg    <= last_next;
        miss_reg    <= miss_next;
        bits_reg    <= bits_next;
        count_reg   <= count_next;
        emitted_reg <= emitted_next;
        obyte_reg   <= obyte_next;
        ohas_reg    <= ohas_next;
        odone_reg   <= odone_next;
        omiss_reg   <= omiss_next;
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_has   = ohas_reg;
    assign out_done  = odone_reg;
    assign out_miss  = omiss_reg;

endmodule
`default_nettype wire

FILE: rtl/core/prefix_code_bit_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_code_bit_packer
// Table-driven prefix code encoder packing code bits LSB first into bytes.
// ----------------------------------------------------------------------------
// table write beats are taken back to back in idle; an encode beat runs idle,
// load, emit, finish and takes no new beat until done, one full byte leaving
// per cycle while m_tready allows; a full byte passes the table RAM read, the
// accumulator and output registers; flush, marker and error bytes leave in finish
// aresetn (synchronous, active low) marks every table entry empty and
// clears the pending byte and token state; no clearing pass is needed
module prefix_code_bit_packer #(
    parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // symbol[7:0], code_word[39:8], code_length[45:40]
    input  wire logic        s_tuser,  // func
    input  wire logic        s_tlast,  // end_of_token
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,  // data_byte
    output logic      [1:0]  m_tuser,  // has_byte[0], miss_error[1]
    output logic             m_tlast   // token_done
);

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

    pcbp_pkg::ctrl_t             ctrl;
    pcbp_pkg::status_t           status;
    logic                        in_encode;
    logic                        hit;
    logic [pcbp_pkg::CODE_W-1:0] rd_code;
    logic [LEN_W-1:0]            rd_len;
    logic                        out_has;
    logic                        out_miss;

    assign in_encode = (s_tuser == pcbp_pkg::FUNC_ENCODE);

    pcbp_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_encode(in_encode),
        .status   (status),
        .in_ready (s_tready),
        .ctrl     (ctrl)
    );

    pcbp_code_table #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .LEN_W       (LEN_W)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (ctrl.take && (s_tuser == pcbp_pkg::FUNC_WRITE)),
        .symbol     (s_tdata[7:0]),
        .code_word  (s_tdata[39:8]),
        .code_length(s_tdata[45:40]),
        .hit        (hit),
        .rd_code    (rd_code),
        .rd_len     (rd_len)
    );

    pcbp_datapath #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .LEN_W       (LEN_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .in_encode(in_encode),
        .in_last  (s_tlast),
        .hit      (hit),
        .rd_code  (rd_code),
        .rd_len   (rd_len),
        .status   (status),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_byte (m_tdata),
        .out_has  (out_has),
        .out_done (m_tlast),
        .out_miss (out_miss)
    );

    assign m_tuser = {out_miss, out_has};

endmodule
`default_nettype wire
